// ----- design/lookahead_peak_limiter_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the look-ahead peak limiter
// Checks are compiled for simulation only; synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef LOOKAHEAD_PEAK_LIMITER_DEFINES_SVH
`define LOOKAHEAD_PEAK_LIMITER_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, muted while reset is high
`define LPL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lookahead_peak_limiter: check failed");
// clocked check that also covers the reset cycles
`define LPL_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lookahead_peak_limiter: check failed");
`else
`define LPL_ASSERT(lbl, clk, rst, prop)
`define LPL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- design/lpl_pkg.sv -----
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared types and constants of the look-ahead peak limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 16;
   localparam int CSR_ADDR_W = 2;

   localparam int DEFAULT_DELAY_LEN = 10;
   localparam int DEFAULT_CHANNELS  = 2;

   // unity gain / full scale amplitude in unsigned Q1.23
   localparam logic [SAMPLE_W-1:0] UNITY = 24'h800000;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 24'd6710886;
   localparam logic [COEF_W-1:0]   ATTACK_RESET    = 16'd6554;
   localparam logic [COEF_W-1:0]   RELEASE_RESET   = 16'd66;

   // one quotient bit per divider step
   localparam int DIV_STEPS = 24;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_ATTACK    = 2'd1,
      CSR_RELEASE   = 2'd2
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic env_mul;
      logic env_upd;
      logic div_start;
      logic gain_mul;
      logic gain_upd;
      logic out_mul;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic out_busy;
   } status_type;

endpackage

// ----- design/lpl_div.sv -----
// ----------------------------------------------------------------------------
// lpl_div
// Restoring divider for the target gain: threshold * 2^23 / peak, clamped
// to unity, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpl_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lpl_pkg::SAMPLE_W-1:0]  dividend,
   input  logic [lpl_pkg::SAMPLE_W-1:0]  divisor,
   output logic                          done,
   output logic [lpl_pkg::SAMPLE_W-1:0]  quotient
);

   logic [lpl_pkg::SAMPLE_W:0]          rem_ff, rem_in;
   logic [lpl_pkg::SAMPLE_W:0]          rem_sub;
   logic [lpl_pkg::SAMPLE_W-1:0]        q_ff, q_in;
   logic [lpl_pkg::DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic                                ge;

   always_comb begin
      ge      = rem_ff >= {1'b0, divisor};
      rem_sub = ge ? (rem_ff - {1'b0, divisor}) : rem_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // zero peak, or a quotient of two or more: the gain clamps to unity
         if (divisor == '0 || {1'b0, dividend} >= {divisor, 1'b0}) begin
            q_in    = lpl_pkg::UNITY;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in  = {1'b0, dividend};
            q_in    = '0;
            cnt_in  = lpl_pkg::DIV_CNT_W'(lpl_pkg::DIV_STEPS - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         q_in   = {q_ff[lpl_pkg::SAMPLE_W-2:0], ge};
         rem_in = {rem_sub[lpl_pkg::SAMPLE_W-1:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = (q_ff > lpl_pkg::UNITY) ? lpl_pkg::UNITY : q_ff;

endmodule

// ----- design/lpl_datapath.sv -----
// ----------------------------------------------------------------------------
// lpl_datapath
// Registers, envelope and gain smoothing, delay memory, output multiply and
// output register of the look-ahead peak limiter.
// ----------------------------------------------------------------------------
module lpl_datapath #(
   parameter int DELAY_LEN = lpl_pkg::DEFAULT_DELAY_LEN,
   parameter int CHANNELS  = lpl_pkg::DEFAULT_CHANNELS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lpl_pkg::cmd_type                   cmd,
   output lpl_pkg::status_type                status,
   input  logic signed [lpl_pkg::SAMPLE_W-1:0] in_sample,
   input  logic                               in_channel,
   input  logic                               csr_we,
   input  logic [lpl_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [lpl_pkg::SAMPLE_W-1:0]       csr_wdata,
   output logic signed [lpl_pkg::SAMPLE_W-1:0] out_sample,
   output logic                               out_channel,
   output logic                               out_valid,
   input  logic                               out_ready
);

   localparam int DEPTH  = CHANNELS * DELAY_LEN;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W  = (DELAY_LEN > 1) ? $clog2(DELAY_LEN) : 1;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SW     = lpl_pkg::SAMPLE_W;
   localparam logic signed [SW+1:0] SAT_MAX = (SW+2)'(8388607);
   localparam logic signed [SW+1:0] SAT_MIN = -(SW+2)'(8388608);

   // configuration
   logic [SW-1:0]                 threshold_ff;
   logic [lpl_pkg::COEF_W-1:0]    attack_ff, release_ff;

   // item payload
   logic signed [SW-1:0]          sample_ff;
   logic                          chan_field_ff;
   logic [CH_W-1:0]               ch_ff, ch_in;
   logic [SW-1:0]                 amp;

   // shared envelope and gain, per-channel delay positions and fill flags
   logic [SW-1:0]                 peak_ff, gain_ff;
   logic [POS_W-1:0]              pos_ff [CHANNELS];
   logic [CHANNELS-1:0]           filled_ff;
   logic [POS_W-1:0]              pos_cur, pos_next;
   logic [ADDR_W-1:0]             addr;

   // delay memory
   logic signed [SW-1:0]          mem [DEPTH];
   logic signed [SW-1:0]          rd_ff;
   logic signed [SW-1:0]          delayed_ff;

   // smoothing unit
   logic                          use_gain;
   logic [SW-1:0]                 sm_old, sm_x;
   logic [lpl_pkg::COEF_W-1:0]    sm_c;
   logic signed [SW:0]            sm_diff;
   logic signed [lpl_pkg::COEF_W:0] sm_cs;
   logic signed [41:0]            sm_prod_in, sm_prod_ff, sm_round;
   logic signed [SW+1:0]          sm_sum;
   logic [SW-1:0]                 sm_new;

   // divider
   logic                          div_done;
   logic [SW-1:0]                 target;

   // output path
   logic signed [2*SW:0]          out_prod_in, out_prod_ff, out_round;
   logic signed [SW+1:0]          out_res;
   logic signed [SW-1:0]          out_sat;
   logic signed [SW-1:0]          rsp_sample_ff;
   logic                          rsp_chan_ff;
   logic                          rsp_valid_ff;

   assign ch_in = (CHANNELS == 1) ? '0 : CH_W'(in_channel);
   assign amp   = sample_ff[SW-1] ? (~sample_ff + 1'b1) : sample_ff;

   assign pos_cur  = pos_ff[ch_ff];
   assign pos_next = (pos_cur >= POS_W'(DELAY_LEN - 1)) ? '0 : pos_cur + 1'b1;
   assign addr     = ADDR_W'(ch_ff) * ADDR_W'(DELAY_LEN) + ADDR_W'(pos_cur);

   // smoothed = old + round(c * (x - old) / 2^16)
   assign use_gain = cmd.gain_mul || cmd.gain_upd;
   always_comb begin
      sm_old = use_gain ? gain_ff : peak_ff;
      sm_x   = use_gain ? target  : amp;
      if (use_gain) begin
         sm_c = (gain_ff > target) ? attack_ff : release_ff;
      end else begin
         sm_c = (amp > peak_ff) ? attack_ff : release_ff;
      end
      sm_diff    = $signed({1'b0, sm_x}) - $signed({1'b0, sm_old});
      sm_cs      = $signed({1'b0, sm_c});
      sm_prod_in = sm_diff * sm_cs;
      sm_round   = (sm_prod_ff + 42'sd32768) >>> 16;
      sm_sum     = $signed({2'b00, sm_old}) + sm_round[SW+1:0];
      sm_new     = sm_sum[SW-1:0];
   end

   // output: round half up, then saturate
   always_comb begin
      out_prod_in = delayed_ff * $signed({1'b0, gain_ff});
      out_round   = (out_prod_ff + (2*SW+1)'(4194304)) >>> 23;
      out_res     = out_round[SW+1:0];
      if (out_res > SAT_MAX) begin
         out_sat = SAT_MAX[SW-1:0];
      end else if (out_res < SAT_MIN) begin
         out_sat = SAT_MIN[SW-1:0];
      end else begin
         out_sat = out_res[SW-1:0];
      end
   end

   lpl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (threshold_ff),
      .divisor  (peak_ff),
      .done     (div_done),
      .quotient (target)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= lpl_pkg::THRESHOLD_RESET;
         attack_ff    <= lpl_pkg::ATTACK_RESET;
         release_ff   <= lpl_pkg::RELEASE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            lpl_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata;
            lpl_pkg::CSR_ATTACK:    attack_ff    <= csr_wdata[lpl_pkg::COEF_W-1:0];
            lpl_pkg::CSR_RELEASE:   release_ff   <= csr_wdata[lpl_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // shared envelope and gain, per-channel positions and fill flags, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         gain_ff      <= lpl_pkg::UNITY;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         if (cmd.env_upd) begin
            peak_ff       <= sm_new;
            pos_ff[ch_ff] <= pos_next;
            if (pos_next == '0) begin
               filled_ff[ch_ff] <= 1'b1;
            end
         end
         if (cmd.gain_upd) begin
            gain_ff <= sm_new;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff     <= in_sample;
         chan_field_ff <= in_channel;
         ch_ff         <= ch_in;
      end
      if (cmd.env_mul || cmd.gain_mul) begin
         sm_prod_ff <= sm_prod_in;
      end
      if (cmd.env_upd) begin
         // a slot never written reads as zero
         delayed_ff <= filled_ff[ch_ff] ? rd_ff : '0;
      end
      if (cmd.out_mul) begin
         out_prod_ff <= out_prod_in;
      end
      if (cmd.out_load) begin
         rsp_sample_ff <= out_sat;
         rsp_chan_ff   <= chan_field_ff;
      end
   end

   // delay memory: read the oldest sample, then overwrite it
   always_ff @(posedge clock) begin
      if (cmd.env_mul) begin
         rd_ff <= mem[addr];
      end
      if (cmd.env_upd) begin
         mem[addr] <= sample_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.out_busy = rsp_valid_ff && !out_ready;

   assign out_sample  = rsp_sample_ff;
   assign out_channel = rsp_chan_ff;
   assign out_valid   = rsp_valid_ff;

endmodule

// ----- design/lpl_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpl_ctrl
// Sequencer of the look-ahead peak limiter: steps one item through envelope,
// divide, gain smoothing and output multiply.
// ----------------------------------------------------------------------------
`include "lookahead_peak_limiter_defines.svh"

module lpl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output lpl_pkg::cmd_type    cmd,
   input  lpl_pkg::status_type status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ENV_MUL,
      S_ENV_UPD,
      S_DIV_START,
      S_DIV_WAIT,
      S_GAIN_MUL,
      S_GAIN_UPD,
      S_OUT_MUL,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_ENV_MUL;
            end
         end
         S_ENV_MUL: begin
            cmd.env_mul = 1'b1;
            state_in    = S_ENV_UPD;
         end
         S_ENV_UPD: begin
            cmd.env_upd = 1'b1;
            state_in    = S_DIV_START;
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_GAIN_MUL;
            end
         end
         S_GAIN_MUL: begin
            cmd.gain_mul = 1'b1;
            state_in     = S_GAIN_UPD;
         end
         S_GAIN_UPD: begin
            cmd.gain_upd = 1'b1;
            state_in     = S_OUT_MUL;
         end
         S_OUT_MUL: begin
            cmd.out_mul = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   `LPL_ASSERT(a_one_item_in_flight, clock, reset, (req_tvalid && req_tready) |=> !req_tready)
   `LPL_ASSERT(a_div_done_in_wait, clock, reset, status.div_done |-> state_ff == S_DIV_WAIT)
   `LPL_ASSERT(a_load_when_free, clock, reset, cmd.out_load |-> !status.out_busy)
   `LPL_ASSERT_ALWAYS(a_reset_to_idle, clock, reset |=> state_ff == S_IDLE)

endmodule

// ----- design/lookahead_peak_limiter.sv -----
// ----------------------------------------------------------------------------
// lookahead_peak_limiter
// Feedforward peak limiter with a shared envelope and gain and a per-channel
// look-ahead delay line.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one item: a signed Q1.23 sample in req_tdata and its channel
//   number in req_tuser. rsp_* returns one item per input: the delayed sample
//   times the smoothed gain, saturated, with the channel echoed in rsp_tuser.
//   csr_* writes threshold (index 0), attack coefficient (1) and release
//   coefficient (2); write only while no item is in flight.
// Sequence:
//   An item steps through the sequencer: capture, envelope multiply and
//   delay memory read, envelope update and delay memory write, divider
//   start and wait on the one-bit-per-cycle restoring divider for
//   threshold / peak, gain smoothing multiply and update, output multiply,
//   output load. The next item is accepted only back in idle. With a zero
//   peak, or a peak at or below half the threshold, the divide steps are
//   skipped and the divider returns unity. rsp_tvalid rises on output load.
// Reset:
//   Envelope clears, gain returns to unity, delay lines read as silence until
//   refilled, registers return to 0.8 / 6554 / 66. No clearing pass is needed.
// Stall:
//   A finished result waits in the output register; the next item is still
//   accepted and processed, and holds only in its last step until rsp frees.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter #(
   parameter int DELAY_LEN = lpl_pkg::DEFAULT_DELAY_LEN,
   parameter int CHANNELS  = lpl_pkg::DEFAULT_CHANNELS
) (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,  // [23:0] sample_in
   input  logic                           req_tuser,  // [0] channel
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,  // [23:0] sample_out
   output logic                           rsp_tuser,  // [0] channel_out
   // configuration write port
   input  logic                           csr_we,
   input  logic [lpl_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lpl_pkg::SAMPLE_W-1:0]   csr_wdata
);

   lpl_pkg::cmd_type    cmd;
   lpl_pkg::status_type status;
   logic signed [lpl_pkg::SAMPLE_W-1:0] out_sample;

   // sequencer: one item at a time, accepts only when idle
   lpl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // arithmetic, state, delay memory and output register
   lpl_datapath #(
      .DELAY_LEN (DELAY_LEN),
      .CHANNELS  (CHANNELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_sample   ($signed(req_tdata)),
      .in_channel  (req_tuser),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .out_sample  (out_sample),
      .out_channel (rsp_tuser),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready)
   );

   assign rsp_tdata = out_sample;

endmodule
